// File: rtl/core/pcorr_pkg.sv
// Shared constants, widths and types for the Pearson correlation block.
// Used by the controller, the datapath and the top level; depends on nothing.
package pcorr_pkg;

    localparam int MAX_PAIRS   = 4096;
    localparam int SAMPLE_BITS = 12;
    localparam int CNT_W       = $clog2(MAX_PAIRS + 1);
    localparam int SUM_W       = SAMPLE_BITS + CNT_W;
    localparam int SQS_W       = 2 * SAMPLE_BITS + CNT_W;
    localparam int VAR_W       = 2 * SAMPLE_BITS + 2 * CNT_W + 1;
    localparam int Q_BITS      = 15;
    localparam int CORR_W      = 16;
    localparam int PCOUNT_W    = 13;
    localparam int ODD_W       = Q_BITS + 1;
    localparam int OSQ_W       = 2 * ODD_W;
    localparam int LHS_SHIFT   = 2 * Q_BITS + 2;
    localparam int ACC_W       = 2 * VAR_W + OSQ_W;
    localparam int MPL_W       = (VAR_W > OSQ_W) ? VAR_W : OSQ_W;

    typedef enum logic [3:0] {
        OP_NSXX,
        OP_SXSX,
        OP_NSYY,
        OP_SYSY,
        OP_NSXY,
        OP_SXSY,
        OP_NUMSQ,
        OP_VXVY,
        OP_TRIAL
    } mul_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_CHECK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic    accept;
        logic    kinit;
        logic    mul_load;
        logic    mul_finish;
        logic    emit;
        mul_op_t op;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic zero_var;
        logic last_bit;
    } status_t;

endpackage

// File: rtl/core/pcorr_ctrl.sv
// Controller state machine that sequences the final products and the root search.
// Depends on pcorr_pkg for the state, operation, command and status types.
module pcorr_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               last_pair,
    input  pcorr_pkg::status_t status,
    output pcorr_pkg::cmd_t    cmd,
    output logic               busy
);

    pcorr_pkg::state_t  state_reg, state_next;
    pcorr_pkg::mul_op_t op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcorr_pkg::ST_IDLE;
            op_reg    <= pcorr_pkg::OP_NSXX;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cmd            = '0;
        cmd.op         = op_reg;
        busy           = 1'b1;
        case (state_reg)
            pcorr_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (last_pair)
                    begin
                        cmd.kinit  = 1'b1;
                        op_next    = pcorr_pkg::OP_NSXX;
                        state_next = pcorr_pkg::ST_LOAD;
                    end
                end
            end
            pcorr_pkg::ST_LOAD:
            begin
                cmd.mul_load = 1'b1;
                state_next   = pcorr_pkg::ST_RUN;
            end
            pcorr_pkg::ST_RUN:
            begin
                if (status.mul_done)
                begin
                    cmd.mul_finish = 1'b1;
                    state_next     = pcorr_pkg::ST_LOAD;
                    case (op_reg)
                        pcorr_pkg::OP_NSXX:  op_next = pcorr_pkg::OP_SXSX;
                        pcorr_pkg::OP_SXSX:  op_next = pcorr_pkg::OP_NSYY;
                        pcorr_pkg::OP_NSYY:  op_next = pcorr_pkg::OP_SYSY;
                        pcorr_pkg::OP_SYSY:  op_next = pcorr_pkg::OP_NSXY;
                        pcorr_pkg::OP_NSXY:  op_next = pcorr_pkg::OP_SXSY;
                        pcorr_pkg::OP_SXSY:  state_next = pcorr_pkg::ST_CHECK;
                        pcorr_pkg::OP_NUMSQ: op_next = pcorr_pkg::OP_VXVY;
                        pcorr_pkg::OP_VXVY:  op_next = pcorr_pkg::OP_TRIAL;
                        pcorr_pkg::OP_TRIAL:
                        begin
                            if (status.last_bit)
                            begin
                                state_next = pcorr_pkg::ST_EMIT;
                            end
                        end
                        default: state_next = pcorr_pkg::ST_EMIT;
                    endcase
                end
            end
            pcorr_pkg::ST_CHECK:
            begin
                if (status.zero_var)
                begin
                    state_next = pcorr_pkg::ST_EMIT;
                end
                else
                begin
                    op_next    = pcorr_pkg::OP_NUMSQ;
                    state_next = pcorr_pkg::ST_LOAD;
                end
            end
            pcorr_pkg::ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = pcorr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pcorr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/pcorr_dpath.sv
// Datapath: running sums, a shift-add multiplier, the variance terms and the root search.
// Depends on pcorr_pkg for widths and the command and status types.
module pcorr_dpath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pcorr_pkg::cmd_t                        cmd,
    input  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] x_sample,
    input  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] y_sample,
    output pcorr_pkg::status_t                     status,
    output logic                                   done,
    output logic signed [pcorr_pkg::CORR_W-1:0]    corr,
    output logic                                   zero_variance,
    output logic                                   capacity_overflow,
    output logic [pcorr_pkg::PCOUNT_W-1:0]         pair_count
);

    localparam int VW = pcorr_pkg::VAR_W;
    localparam int AW = pcorr_pkg::ACC_W;
    localparam int MW = pcorr_pkg::MPL_W;

    logic [pcorr_pkg::CNT_W-1:0]        count_reg;
    logic signed [pcorr_pkg::SUM_W-1:0] sum_x_reg, sum_y_reg;
    logic signed [pcorr_pkg::SQS_W-1:0] sum_xx_reg, sum_yy_reg, sum_xy_reg;
    logic                               ovf_reg;
    logic [AW-1:0]                      acc_reg, mcand_reg;
    logic [MW-1:0]                      mplier_reg;
    logic                               psign_reg;
    logic signed [VW-1:0]               tmp_reg, vx_reg, vy_reg, num_reg;
    logic [AW-1:0]                      lhs_reg;
    logic [2*VW-1:0]                    vv_reg;
    logic [pcorr_pkg::Q_BITS-1:0]       k_reg, kbit_reg;
    logic                               done_reg, zv_reg, ovfo_reg;
    logic signed [pcorr_pkg::CORR_W-1:0] corr_reg;
    logic [pcorr_pkg::PCOUNT_W-1:0]     pcount_reg;

    logic signed [2*pcorr_pkg::SAMPLE_BITS-1:0] xx, yy, xy;
    logic [AW-1:0]                      mcand_sel;
    logic [MW-1:0]                      mplier_sel;
    logic                               psign_sel;
    logic [pcorr_pkg::Q_BITS-1:0]       trial;
    logic [pcorr_pkg::ODD_W-1:0]        odd;
    logic [pcorr_pkg::OSQ_W-1:0]        oddsq;
    logic signed [VW-1:0]               acc_s, acc_signed;
    logic                               full;
    logic                               zv_now;
    logic [pcorr_pkg::CORR_W-1:0]       kmag;

    function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] v);
        return v[VW-1] ? VW'(-v) : VW'(v);
    endfunction

    assign xx    = x_sample * x_sample;
    assign yy    = y_sample * y_sample;
    assign xy    = x_sample * y_sample;
    assign full  = (count_reg == pcorr_pkg::CNT_W'(pcorr_pkg::MAX_PAIRS));
    assign trial = k_reg | kbit_reg;
    assign odd   = {trial, 1'b0} - pcorr_pkg::ODD_W'(1);
    assign oddsq = odd * odd;
    assign acc_s = VW'(acc_reg);
    assign acc_signed = psign_reg ? -acc_s : acc_s;
    assign zv_now = (vx_reg <= 0) || (vy_reg <= 0);
    assign kmag  = pcorr_pkg::CORR_W'(k_reg);

    always_comb
    begin
        mcand_sel  = '0;
        mplier_sel = '0;
        psign_sel  = 1'b0;
        case (cmd.op)
            pcorr_pkg::OP_NSXX:
            begin
                mcand_sel  = AW'(mag(VW'(sum_xx_reg)));
                mplier_sel = MW'(count_reg);
            end
            pcorr_pkg::OP_SXSX:
            begin
                mcand_sel  = AW'(mag(VW'(sum_x_reg)));
                mplier_sel = MW'(mag(VW'(sum_x_reg)));
            end
            pcorr_pkg::OP_NSYY:
            begin
                mcand_sel  = AW'(mag(VW'(sum_yy_reg)));
                mplier_sel = MW'(count_reg);
            end
            pcorr_pkg::OP_SYSY:
            begin
                mcand_sel  = AW'(mag(VW'(sum_y_reg)));
                mplier_sel = MW'(mag(VW'(sum_y_reg)));
            end
            pcorr_pkg::OP_NSXY:
            begin
                mcand_sel  = AW'(mag(VW'(sum_xy_reg)));
                mplier_sel = MW'(count_reg);
                psign_sel  = sum_xy_reg[pcorr_pkg::SQS_W-1];
            end
            pcorr_pkg::OP_SXSY:
            begin
                mcand_sel  = AW'(mag(VW'(sum_x_reg)));
                mplier_sel = MW'(mag(VW'(sum_y_reg)));
                psign_sel  = sum_x_reg[pcorr_pkg::SUM_W-1] ^ sum_y_reg[pcorr_pkg::SUM_W-1];
            end
            pcorr_pkg::OP_NUMSQ:
            begin
                mcand_sel  = AW'(mag(num_reg));
                mplier_sel = MW'(mag(num_reg));
            end
            pcorr_pkg::OP_VXVY:
            begin
                mcand_sel  = AW'(mag(vx_reg));
                mplier_sel = MW'(mag(vy_reg));
            end
            pcorr_pkg::OP_TRIAL:
            begin
                mcand_sel  = AW'(vv_reg);
                mplier_sel = MW'(oddsq);
            end
            default:
            begin
                mcand_sel  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            sum_xy_reg <= '0;
            ovf_reg    <= 1'b0;
            mplier_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.emit)
            begin
                count_reg  <= '0;
                sum_x_reg  <= '0;
                sum_y_reg  <= '0;
                sum_xx_reg <= '0;
                sum_yy_reg <= '0;
                sum_xy_reg <= '0;
                ovf_reg    <= 1'b0;
            end
            else if (cmd.accept)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg  <= count_reg + pcorr_pkg::CNT_W'(1);
                    sum_x_reg  <= sum_x_reg + pcorr_pkg::SUM_W'(x_sample);
                    sum_y_reg  <= sum_y_reg + pcorr_pkg::SUM_W'(y_sample);
                    sum_xx_reg <= sum_xx_reg + pcorr_pkg::SQS_W'(xx);
                    sum_yy_reg <= sum_yy_reg + pcorr_pkg::SQS_W'(yy);
                    sum_xy_reg <= sum_xy_reg + pcorr_pkg::SQS_W'(xy);
                end
            end
            if (cmd.mul_load)
            begin
                mplier_reg <= mplier_sel;
            end
            else if (mplier_reg != '0)
            begin
                mplier_reg <= mplier_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            acc_reg   <= '0;
            mcand_reg <= mcand_sel;
            psign_reg <= psign_sel;
        end
        else if (mplier_reg != '0)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg <= mcand_reg << 1;
        end
        if (cmd.kinit)
        begin
            k_reg    <= '0;
            kbit_reg <= {1'b1, {(pcorr_pkg::Q_BITS-1){1'b0}}};
        end
        if (cmd.mul_finish)
        begin
            case (cmd.op)
                pcorr_pkg::OP_NSXX,
                pcorr_pkg::OP_NSYY,
                pcorr_pkg::OP_NSXY: tmp_reg <= acc_signed;
                pcorr_pkg::OP_SXSX: vx_reg <= tmp_reg - acc_s;
                pcorr_pkg::OP_SYSY: vy_reg <= tmp_reg - acc_s;
                pcorr_pkg::OP_SXSY: num_reg <= tmp_reg - acc_signed;
                pcorr_pkg::OP_NUMSQ: lhs_reg <= acc_reg << pcorr_pkg::LHS_SHIFT;
                pcorr_pkg::OP_VXVY: vv_reg <= acc_reg[2*VW-1:0];
                pcorr_pkg::OP_TRIAL:
                begin
                    if (lhs_reg >= acc_reg)
                    begin
                        k_reg <= trial;
                    end
                    kbit_reg <= kbit_reg >> 1;
                end
                default: tmp_reg <= tmp_reg;
            endcase
        end
        if (cmd.emit)
        begin
            zv_reg     <= zv_now;
            ovfo_reg   <= ovf_reg;
            pcount_reg <= pcorr_pkg::PCOUNT_W'(count_reg);
            if (zv_now)
            begin
                corr_reg <= '0;
            end
            else if (num_reg[VW-1])
            begin
                corr_reg <= -$signed(kmag);
            end
            else
            begin
                corr_reg <= $signed(kmag);
            end
        end
    end

    assign status.mul_done = (mplier_reg == '0);
    assign status.zero_var = zv_now;
    assign status.last_bit = kbit_reg[0];

    assign done              = done_reg;
    assign corr              = corr_reg;
    assign zero_variance     = zv_reg;
    assign capacity_overflow = ovfo_reg;
    assign pair_count        = pcount_reg;

endmodule

// File: rtl/core/pearson_correlation.sv
// Pearson correlation top level: joins the controller and the datapath.
// Depends on pcorr_pkg, pcorr_ctrl and pcorr_dpath.
// An item is taken when start is high and busy is low; pairs without last_pair
// stream in at one per cycle. The item marked last starts the final computation,
// which runs on a single shift-add multiplier that retires one multiplier bit per
// cycle, with a load step and a finish step for each product. How long busy then
// stays high is set by the bit lengths of the multipliers. The six products that form
// the variances and the numerator come first, and a zero variance ends the run right
// after them. Otherwise the square of the numerator, the product of the variances and
// the fifteen root search products follow. The result appears for exactly one cycle
// with done high, in the first cycle that busy is low again, and cannot be held off
// by the receiver.
module pearson_correlation
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] x_sample,
    input  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] y_sample,
    input  logic                                     last_pair,
    output logic                                     done,
    output logic signed [pcorr_pkg::CORR_W-1:0]      corr,
    output logic                                     zero_variance,
    output logic                                     capacity_overflow,
    output logic [pcorr_pkg::PCOUNT_W-1:0]           pair_count
);

    pcorr_pkg::cmd_t    cmd;
    pcorr_pkg::status_t status;

    pcorr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_pair (last_pair),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    pcorr_dpath u_dpath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .x_sample          (x_sample),
        .y_sample          (y_sample),
        .status            (status),
        .done              (done),
        .corr              (corr),
        .zero_variance     (zero_variance),
        .capacity_overflow (capacity_overflow),
        .pair_count        (pair_count)
    );

endmodule

// File: tb/sv/tb_pearson_correlation.sv
// Testbench for pearson_correlation: streams paired samples, predicts each result.
// Depends on pcorr_pkg and the pearson_correlation RTL; self-checking, no files read.
`timescale 1ns / 100ps

module tb_pearson_correlation;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic signed [pcorr_pkg::CORR_W-1:0] corr;
        logic                                zero_variance;
        logic                                capacity_overflow;
        logic [pcorr_pkg::PCOUNT_W-1:0]      pair_count;
    } corr_result_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [pcorr_pkg::SAMPLE_BITS-1:0] x_sample;
    logic signed [pcorr_pkg::SAMPLE_BITS-1:0] y_sample;
    logic last_pair;
    logic done;
    logic signed [pcorr_pkg::CORR_W-1:0] corr;
    logic zero_variance;
    logic capacity_overflow;
    logic [pcorr_pkg::PCOUNT_W-1:0] pair_count;

    corr_result_t expected_results[$];
    int  series_len;
    longint acc_x, acc_y, acc_xx, acc_yy, acc_xy;
    bit  dropped;
    int  idle_pct;
    int  error_count;
    int  items_sent;
    int  results_seen;
    int  quiet_cycles;

    pearson_correlation dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .x_sample(x_sample), .y_sample(y_sample), .last_pair(last_pair),
        .done(done), .corr(corr), .zero_variance(zero_variance),
        .capacity_overflow(capacity_overflow), .pair_count(pair_count)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic report(input string msg);
        begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
            error_count++;
        end
    endtask

    function automatic logic [14:0] corr_magnitude(input logic [63:0] a,
                                                   input logic [63:0] vx,
                                                   input logic [63:0] vy);
        logic [191:0] lhs;
        logic [191:0] prod;
        logic [191:0] rhs;
        logic [191:0] odd;
        int lo;
        int hi;
        int mid;
        begin
            lhs  = ({128'b0, a} * {128'b0, a}) << 32;
            prod = {128'b0, vx} * {128'b0, vy};
            lo = 0;
            hi = 32767;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                odd = 192'(2 * mid - 1);
                rhs = prod * (odd * odd);
                if (lhs >= rhs)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            return lo[14:0];
        end
    endfunction

    task automatic predict_pair(input logic signed [pcorr_pkg::SAMPLE_BITS-1:0] x,
                                input logic signed [pcorr_pkg::SAMPLE_BITS-1:0] y,
                                input bit last);
        longint n;
        longint vx;
        longint vy;
        longint num;
        logic [63:0] a;
        logic [14:0] k;
        corr_result_t r;
        begin
            if (series_len < pcorr_pkg::MAX_PAIRS)
            begin
                series_len++;
                acc_x  += x;
                acc_y  += y;
                acc_xx += longint'(x) * x;
                acc_yy += longint'(y) * y;
                acc_xy += longint'(x) * y;
            end
            else
                dropped = 1'b1;
            if (last)
            begin
                n   = series_len;
                vx  = n * acc_xx - acc_x * acc_x;
                vy  = n * acc_yy - acc_y * acc_y;
                num = n * acc_xy - acc_x * acc_y;
                r.zero_variance = (vx <= 0) || (vy <= 0);
                r.corr = '0;
                if (!r.zero_variance)
                begin
                    a = (num < 0) ? -num : num;
                    k = corr_magnitude(a, vx, vy);
                    r.corr = (num < 0) ? -$signed({1'b0, k}) : $signed({1'b0, k});
                end
                r.capacity_overflow = dropped;
                r.pair_count = series_len[pcorr_pkg::PCOUNT_W-1:0];
                expected_results = {expected_results, r};
                series_len = 0;
                acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
                dropped = 1'b0;
            end
        end
    endtask

    task automatic send_pair(input int x, input int y, input bit last);
        int gap;
        begin
            start     <= 1'b1;
            x_sample  <= x[pcorr_pkg::SAMPLE_BITS-1:0];
            y_sample  <= y[pcorr_pkg::SAMPLE_BITS-1:0];
            last_pair <= last;
            @(negedge clk);
            while (busy)
                @(negedge clk);
            @(posedge clk);
            predict_pair(x[pcorr_pkg::SAMPLE_BITS-1:0], y[pcorr_pkg::SAMPLE_BITS-1:0], last);
            items_sent++;
            if ($urandom_range(99) < idle_pct)
            begin
                gap = $urandom_range(6, 1);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain;
        begin
            start <= 1'b0;
            while (expected_results.size() != 0)
                @(posedge clk);
            repeat (20) @(posedge clk);
        end
    endtask

    function automatic int clamp_sample(input int v);
        begin
            if (v > 2047)
                return 2047;
            if (v < -2048)
                return -2048;
            return v;
        end
    endfunction

    task automatic test_directed;
        begin
            send_pair(5, -7, 1);
            send_pair(-2048, -2048, 0);
            send_pair(2047, 2047, 1);
            send_pair(-2048, 2047, 0);
            send_pair(2047, -2048, 0);
            send_pair(0, 0, 1);
            send_pair(100, 3, 0);
            send_pair(100, -900, 0);
            send_pair(100, 1200, 1);
            send_pair(-40, 7, 0);
            send_pair(600, 7, 0);
            send_pair(-1, 7, 1);
            send_pair(-2048, 1, 0);
            send_pair(0, 2, 0);
            send_pair(2047, 4, 1);
            send_pair(-2048, 2047, 0);
            send_pair(0, 0, 0);
            send_pair(2047, -2048, 1);
            send_pair(-1365, 1, 0);
            send_pair(3, 2047, 0);
            send_pair(-7, -2048, 0);
            send_pair(1111, 0, 1);
            drain();
        end
    endtask

    task automatic test_random(input int pct, input int n_items);
        int sent;
        int len;
        int mode;
        int x;
        int y;
        int sgn;
        int noise;
        begin
            idle_pct = pct;
            sent = 0;
            while (sent < n_items)
            begin
                len  = ($urandom_range(9) == 0) ? 1 : $urandom_range(24, 2);
                mode = $urandom_range(4);
                sgn  = $urandom_range(1) ? 1 : -1;
                noise = (1 << $urandom_range(11));
                for (int i = 0; i < len; i++)
                begin
                    x = $urandom_range(4095) - 2048;
                    case (mode)
                        0: y = $urandom_range(4095) - 2048;
                        1: y = clamp_sample(sgn * x + $urandom_range(noise) - noise / 2);
                        2: y = sgn * 777;
                        3: begin
                            x = $urandom_range(15) - 8;
                            y = $urandom_range(15) - 8;
                        end
                        default: y = (sgn > 0) ? x : clamp_sample(-x);
                    endcase
                    if (mode == 2 && $urandom_range(1))
                    begin
                        x = y;
                        y = $urandom_range(4095) - 2048;
                    end
                    send_pair(x, y, i == len - 1);
                end
                sent += len;
            end
            drain();
        end
    endtask

    always @(negedge clk)
    begin
        corr_result_t e;
        if (done)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report("result with no expectation waiting");
            else
            begin
                e = expected_results.pop_front();
                if (corr !== e.corr)
                    report($sformatf("corr %0d, expected %0d", corr, e.corr));
                if (zero_variance !== e.zero_variance)
                    report($sformatf("zero_variance %b, expected %b",
                                     zero_variance, e.zero_variance));
                if (capacity_overflow !== e.capacity_overflow)
                    report($sformatf("capacity_overflow %b, expected %b",
                                     capacity_overflow, e.capacity_overflow));
                if (pair_count !== e.pair_count)
                    report($sformatf("pair_count %0d, expected %0d",
                                     pair_count, e.pair_count));
            end
        end
        if (!rst_n || done || (start && !busy))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        x_sample = '0;
        y_sample = '0;
        last_pair = 1'b0;
        series_len = 0;
        acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
        dropped = 1'b0;
        idle_pct = 0;
        error_count = 0;
        items_sent = 0;
        results_seen = 0;
        quiet_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(0, 140);
        test_random(65, 140);
        test_random(0, 140);
        test_random(35, 140);
        $display("Sent %0d pairs and checked %0d correlation results,", items_sent,
                 results_seen);
        $display("including zero variance, perfect correlation and full-scale samples.");
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
